### hw/rtl/bbm_pkg.sv
`default_nettype none

package bbm_pkg;

  localparam int BLOCK_PIXELS = 16;
  localparam int BLOCK_SHIFT  = $clog2(BLOCK_PIXELS);

  localparam int PIX_W   = 11;
  localparam int COORD_W = PIX_W - BLOCK_SHIFT;
  localparam int SIZE_W  = 7;
  localparam int BITS_W  = 24;
  localparam int QP_W    = 6;
  localparam int QPF_W   = 14;
  localparam int CNT_W   = 4;
  localparam int IDX_W   = 16;
  localparam int PNUM_W  = 16;
  localparam int ERR_W   = 2;
  localparam int SPAN_W  = 4;
  localparam int BLKS_W  = 7;
  localparam int SUM_W   = 30;
  localparam int NUM_W   = 19;

  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_GEOM    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SHORT   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OUTSIDE = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CU    = 2'd1,
    OP_CTB   = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_SMALL,
    CMD_STORE,
    CMD_LARGE,
    CMD_TREE,
    CMD_READ
  } cmd_kind_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_RD_ADDR,
    BK_RD_DATA,
    BK_DIV_GO,
    BK_DIV,
    BK_CHECK,
    BK_WRITE,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [COORD_W-1:0]  xb;
    logic [COORD_W-1:0]  yb;
    logic [SPAN_W-1:0]   nc;
    logic [SPAN_W-1:0]   nr;
    logic [BITS_W-1:0]   bits;
    logic [QP_W-1:0]     qp;
    logic [IDX_W-1:0]    idx;
    logic [ERR_W-1:0]    err;
    logic [PNUM_W-1:0]   pnum;
    logic                skip;
  } cmd_t;

  typedef struct packed {
    logic [BITS_W-1:0] bits;
    logic [QPF_W-1:0]  qp;
    logic [BITS_W-1:0] cu_bits;
    logic [CNT_W-1:0]  cnt;
  } map_t;

  typedef struct packed {
    logic [BITS_W-1:0] bits;
    logic [IDX_W-1:0]  idx;
  } ctb_t;

  typedef struct packed {
    logic [BITS_W-1:0]  block_bits;
    logic [QP_W-1:0]    block_qp;
    logic [BITS_W-1:0]  cu_bits;
    logic [BITS_W-1:0]  ctb_bits;
    logic [IDX_W-1:0]   ctb_id;
    logic [COORD_W-1:0] last_col;
    logic [COORD_W-1:0] last_row;
    logic [PNUM_W-1:0]  pnum;
    logic               skip;
    logic [ERR_W-1:0]   err;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/bbm_fifo.sv
`default_nettype none

module bbm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]      rd_ptr_r, rd_ptr_nxt;

  assign empty    = (wr_ptr_r == rd_ptr_r);
  assign full     = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign pop_data = mem_r[rd_ptr_r[AW-1:0]];

  always_comb begin
    wr_ptr_nxt = (push && !full) ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = (pop && !empty) ? rd_ptr_r + 1'b1 : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r[AW-1:0]] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bbm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module bbm_div #(
  parameter int DW = 24,
  parameter int VW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient,
  output logic [VW-1:0]      remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   trial;

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  always_comb begin
    trial    = {rem_r, quo_r[DW-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = VW'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bbm_front.sv
`default_nettype none

// Holds the picture state and turns each accepted item into a command
// for the back end, with geometry checks already resolved.
module bbm_front #(
  parameter int GRID_COLS       = 128,
  parameter int GRID_ROWS       = 128,
  parameter int MAX_UNIT_BLOCKS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [1:0]          opcode,
  input  wire logic [10:0]         x_pixel,
  input  wire logic [10:0]         y_pixel,
  input  wire logic [6:0]          unit_size,
  input  wire logic [23:0]         unit_bits,
  input  wire logic [5:0]          unit_qp,
  input  wire logic [15:0]         tree_block_index,
  input  wire logic signed [31:0]  picture_order,
  input  wire logic [10:0]         picture_width,
  input  wire logic [10:0]         picture_height,
  output bbm_pkg::cmd_t            cmd
);

  import bbm_pkg::*;

  logic [31:0]        poc_r, poc_nxt;
  logic [PNUM_W-1:0]  count_r, count_nxt;
  logic [PIX_W-1:0]   width_r, width_nxt;
  logic [PIX_W-1:0]   height_r, height_nxt;
  logic               skip_r, skip_nxt;

  opcode_t            op;
  logic [COORD_W-1:0] xb, yb;
  logic               aligned, on_grid, new_pic;
  logic [2:0]         n_blk;
  logic [COORD_W:0]   tot_c, tot_r, diff_c, diff_r;
  logic [SPAN_W-1:0]  nc, nr;
  logic [ERR_W-1:0]   reg_err;

  always_comb begin
    op      = opcode_t'(opcode);
    xb      = x_pixel[PIX_W-1:BLOCK_SHIFT];
    yb      = y_pixel[PIX_W-1:BLOCK_SHIFT];
    aligned = (x_pixel[BLOCK_SHIFT-1:0] == '0) && (y_pixel[BLOCK_SHIFT-1:0] == '0);
    on_grid = (int'(xb) < GRID_COLS) && (int'(yb) < GRID_ROWS);
    n_blk   = unit_size[SIZE_W-1:BLOCK_SHIFT];
    new_pic = ($unsigned(picture_order) != poc_r);

    // Blocks touched by the picture, rounded up.
    tot_c  = (COORD_W+1)'(({1'b0, width_r} + 12'd15) >> BLOCK_SHIFT);
    tot_r  = (COORD_W+1)'(({1'b0, height_r} + 12'd15) >> BLOCK_SHIFT);
    diff_c = tot_c - {1'b0, xb};
    diff_r = tot_r - {1'b0, yb};

    if ({1'b0, xb} >= tot_c) begin
      nc = '0;
    end else if (diff_c < (COORD_W+1)'(n_blk)) begin
      nc = SPAN_W'(diff_c);
    end else begin
      nc = SPAN_W'(n_blk);
    end
    if ({1'b0, yb} >= tot_r) begin
      nr = '0;
    end else if (diff_r < (COORD_W+1)'(n_blk)) begin
      nr = SPAN_W'(diff_r);
    end else begin
      nr = SPAN_W'(n_blk);
    end

    if (unit_size[BLOCK_SHIFT-1:0] != '0 || unit_size <= 7'd16 || !aligned ||
        int'(n_blk) > MAX_UNIT_BLOCKS) begin
      reg_err = ERR_GEOM;
    end else if (nc == '0 || nr == '0) begin
      reg_err = ERR_OUTSIDE;
    end else if (int'(xb) + int'(nc) > GRID_COLS || int'(yb) + int'(nr) > GRID_ROWS) begin
      reg_err = ERR_GEOM;
    end else begin
      reg_err = ERR_OK;
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = CMD_NOP;
    cmd.xb   = xb;
    cmd.yb   = yb;
    cmd.nc   = SPAN_W'(1);
    cmd.nr   = SPAN_W'(1);
    cmd.bits = unit_bits;
    cmd.qp   = unit_qp;
    cmd.idx  = tree_block_index;
    cmd.err  = ERR_OK;
    cmd.pnum = count_r - 1'b1;
    cmd.skip = skip_r;
    case (op)
      OP_START: begin
        if (new_pic) begin
          cmd.kind = CMD_CLEAR;
          cmd.pnum = count_r;
          cmd.skip = 1'b0;
        end else begin
          cmd.skip = 1'b1;
        end
      end
      OP_CU: begin
        if (unit_size < 7'd16) begin
          if (on_grid) cmd.kind = CMD_SMALL;
          else         cmd.err  = ERR_GEOM;
        end else if (unit_size == 7'd16) begin
          if (aligned && on_grid) cmd.kind = CMD_STORE;
          else                    cmd.err  = ERR_GEOM;
        end else if (reg_err == ERR_OK) begin
          cmd.kind = CMD_LARGE;
          cmd.nc   = nc;
          cmd.nr   = nr;
        end else begin
          cmd.err = ERR_GEOM;
        end
      end
      OP_CTB: begin
        if (!skip_r) begin
          if (reg_err == ERR_OK) begin
            cmd.kind = CMD_TREE;
            cmd.nc   = nc;
            cmd.nr   = nr;
          end else begin
            cmd.err = reg_err;
          end
        end
      end
      OP_READ: begin
        if (on_grid) cmd.kind = CMD_READ;
        else         cmd.err  = ERR_GEOM;
      end
      default: cmd.kind = CMD_NOP;
    endcase
  end

  always_comb begin
    poc_nxt    = poc_r;
    count_nxt  = count_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    skip_nxt   = skip_r;
    if (accept && op == OP_START) begin
      if (new_pic) begin
        poc_nxt    = $unsigned(picture_order);
        count_nxt  = count_r + 1'b1;
        width_nxt  = picture_width;
        height_nxt = picture_height;
        skip_nxt   = 1'b0;
      end else begin
        skip_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poc_r    <= '1;
      count_r  <= '0;
      width_r  <= '0;
      height_r <= '0;
      skip_r   <= 1'b0;
    end else begin
      poc_r    <= poc_nxt;
      count_r  <= count_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bbm_back.sv
`default_nettype none

// Carries out commands on the block map memories, one block access at a time.
module bbm_back #(
  parameter int GRID_COLS = 128,
  parameter int GRID_ROWS = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire bbm_pkg::cmd_t cmd_in,
  input  wire logic       cmd_empty,
  output logic            cmd_pop,
  output bbm_pkg::res_t   res_out,
  input  wire logic       res_full,
  output logic            res_push,
  output logic            init_busy
);

  import bbm_pkg::*;

  localparam int CELLS  = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(GRID_COLS);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(CELLS - 1);

  map_t map_mem [CELLS];
  ctb_t ctb_mem [CELLS];

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic               init_r, init_nxt;
  logic               pass2_r, pass2_nxt;
  logic [SPAN_W-1:0]  r_r, r_nxt, c_r, c_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  map_t               old_r, old_nxt;
  logic [BITS_W-1:0]  share_r, share_nxt;
  logic [BLKS_W-1:0]  rem_cnt_r, rem_cnt_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;
  map_t               omap_r, omap_nxt;
  ctb_t               octb_r, octb_nxt;
  logic [COORD_W-1:0] max_col_r, max_col_nxt, max_row_r, max_row_nxt;
  map_t               rd_map_r;
  ctb_t               rd_ctb_r;

  logic               rd_en, map_we, ctb_we;
  logic [ADDR_W-1:0]  addr, cur_addr;
  map_t               map_wd;
  ctb_t               ctb_wd;
  logic [COORD_W-1:0] col, row;
  logic               last_blk, row_end, extra;
  logic [BLKS_W-1:0]  blocks;
  logic [BITS_W:0]    sat_bits, sat_cu;

  logic               div_start, div_done;
  logic [BITS_W-1:0]  div_dividend, div_quo;
  logic [BLKS_W-1:0]  div_divisor, div_rem;

  bbm_div #(.DW(BITS_W), .VW(BLKS_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    col      = cmd_r.xb + COORD_W'(c_r);
    row      = cmd_r.yb + COORD_W'(r_r);
    cur_addr = ADDR_W'(row) * COLS_A + ADDR_W'(col);
    row_end  = (c_r == cmd_r.nc - 1'b1);
    last_blk = row_end && (r_r == cmd_r.nr - 1'b1);
    blocks   = BLKS_W'(cmd_r.nc) * BLKS_W'(cmd_r.nr);
    extra    = (rem_cnt_r != '0);
    sat_bits = {1'b0, old_r.bits} + {1'b0, cmd_r.bits};
    sat_cu   = {1'b0, old_r.cu_bits} + {1'b0, cmd_r.bits};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!init_r && !cmd_empty && !res_full) begin
          case (cmd_in.kind)
            CMD_CLEAR: state_nxt = BK_CLEAR;
            CMD_READ,
            CMD_SMALL,
            CMD_TREE:  state_nxt = BK_RD_ADDR;
            CMD_STORE: state_nxt = BK_WRITE;
            CMD_LARGE: state_nxt = BK_DIV_GO;
            default:   state_nxt = BK_DONE;
          endcase
        end
      end
      BK_CLEAR: begin
        if (clr_r == LAST_A) state_nxt = init_r ? BK_IDLE : BK_DONE;
      end
      BK_RD_ADDR: state_nxt = BK_RD_DATA;
      BK_RD_DATA: begin
        case (cmd_r.kind)
          CMD_SMALL: state_nxt = BK_DIV_GO;
          CMD_TREE: begin
            if (!last_blk)    state_nxt = BK_RD_ADDR;
            else if (pass2_r) state_nxt = BK_DONE;
            else              state_nxt = BK_CHECK;
          end
          default: state_nxt = BK_DONE;
        endcase
      end
      BK_DIV_GO: state_nxt = BK_DIV;
      BK_DIV: begin
        if (div_done) state_nxt = (cmd_r.kind == CMD_TREE) ? BK_RD_ADDR : BK_WRITE;
      end
      BK_CHECK: begin
        state_nxt = (sum_r > SUM_W'(cmd_r.bits)) ? BK_DONE : BK_DIV_GO;
      end
      BK_WRITE: begin
        if (cmd_r.kind != CMD_LARGE || last_blk) state_nxt = BK_DONE;
      end
      BK_DONE: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cmd_nxt      = cmd_r;
    init_nxt     = init_r;
    pass2_nxt    = pass2_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    clr_nxt      = clr_r;
    sum_nxt      = sum_r;
    num_nxt      = num_r;
    old_nxt      = old_r;
    share_nxt    = share_r;
    rem_cnt_nxt  = rem_cnt_r;
    err_nxt      = err_r;
    omap_nxt     = omap_r;
    octb_nxt     = octb_r;
    max_col_nxt  = max_col_r;
    max_row_nxt  = max_row_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    rd_en        = 1'b0;
    map_we       = 1'b0;
    ctb_we       = 1'b0;
    addr         = cur_addr;
    map_wd       = '0;
    ctb_wd       = '0;
    div_start    = 1'b0;
    div_dividend = cmd_r.bits;
    div_divisor  = blocks;
    case (state_r)
      BK_IDLE: begin
        if (!init_r && !cmd_empty && !res_full) begin
          cmd_pop     = 1'b1;
          cmd_nxt     = cmd_in;
          err_nxt     = cmd_in.err;
          r_nxt       = '0;
          c_nxt       = '0;
          clr_nxt     = '0;
          sum_nxt     = '0;
          pass2_nxt   = 1'b0;
          rem_cnt_nxt = '0;
          omap_nxt    = '0;
          octb_nxt    = '0;
        end
      end
      BK_CLEAR: begin
        addr    = clr_r;
        map_we  = 1'b1;
        ctb_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_A) begin
          init_nxt    = 1'b0;
          max_col_nxt = '0;
          max_row_nxt = '0;
        end
      end
      BK_RD_ADDR: rd_en = 1'b1;
      BK_RD_DATA: begin
        case (cmd_r.kind)
          CMD_READ: begin
            omap_nxt = rd_map_r;
            octb_nxt = rd_ctb_r;
          end
          CMD_SMALL: begin
            old_nxt = rd_map_r;
            num_nxt = NUM_W'(rd_map_r.qp) * NUM_W'(rd_map_r.cnt) +
                      NUM_W'({cmd_r.qp, 8'd0});
          end
          CMD_TREE: begin
            if (pass2_r) begin
              map_we          = 1'b1;
              map_wd          = rd_map_r;
              map_wd.bits     = rd_map_r.bits + share_r + BITS_W'(extra);
              ctb_we          = 1'b1;
              ctb_wd.bits     = cmd_r.bits;
              ctb_wd.idx      = cmd_r.idx;
              if (extra) rem_cnt_nxt = rem_cnt_r - 1'b1;
            end else begin
              sum_nxt = sum_r + SUM_W'(rd_map_r.bits);
            end
            if (!last_blk) begin
              c_nxt = row_end ? '0 : c_r + 1'b1;
              r_nxt = row_end ? r_r + 1'b1 : r_r;
            end
          end
          default: ;
        endcase
      end
      BK_DIV_GO: begin
        div_start = 1'b1;
        r_nxt     = '0;
        c_nxt     = '0;
        case (cmd_r.kind)
          CMD_SMALL: begin
            div_dividend = BITS_W'(num_r);
            div_divisor  = BLKS_W'(old_r.cnt) + 1'b1;
          end
          CMD_TREE: div_dividend = cmd_r.bits - BITS_W'(sum_r);
          default: ;
        endcase
      end
      BK_DIV: begin
        if (div_done) begin
          share_nxt   = div_quo;
          rem_cnt_nxt = (cmd_r.kind == CMD_SMALL) ? '0 : div_rem;
          pass2_nxt   = 1'b1;
        end
      end
      BK_CHECK: begin
        if (sum_r > SUM_W'(cmd_r.bits)) err_nxt = ERR_SHORT;
      end
      BK_WRITE: begin
        map_we = 1'b1;
        if (col > max_col_r) max_col_nxt = col;
        if (row > max_row_r) max_row_nxt = row;
        case (cmd_r.kind)
          CMD_SMALL: begin
            map_wd.bits    = sat_bits[BITS_W] ? '1 : sat_bits[BITS_W-1:0];
            map_wd.cu_bits = sat_cu[BITS_W] ? '1 : sat_cu[BITS_W-1:0];
            map_wd.qp      = share_r[QPF_W-1:0];
            map_wd.cnt     = (old_r.cnt < CNT_MAX) ? old_r.cnt + 1'b1 : CNT_MAX;
          end
          CMD_LARGE: begin
            map_wd.bits    = share_r + BITS_W'(extra);
            map_wd.cu_bits = cmd_r.bits;
            map_wd.qp      = {cmd_r.qp, 8'd0};
            map_wd.cnt     = '0;
            if (extra) rem_cnt_nxt = rem_cnt_r - 1'b1;
            c_nxt = row_end ? '0 : c_r + 1'b1;
            r_nxt = row_end ? r_r + 1'b1 : r_r;
          end
          default: begin
            map_wd.bits    = cmd_r.bits;
            map_wd.cu_bits = cmd_r.bits;
            map_wd.qp      = {cmd_r.qp, 8'd0};
            map_wd.cnt     = CNT_W'(1);
          end
        endcase
      end
      BK_DONE: res_push = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res_out            = '0;
    res_out.block_bits = omap_r.bits;
    res_out.block_qp   = omap_r.qp[QPF_W-1:8];
    res_out.cu_bits    = omap_r.cu_bits;
    res_out.ctb_bits   = octb_r.bits;
    res_out.ctb_id     = octb_r.idx;
    res_out.last_col   = max_col_r;
    res_out.last_row   = max_row_r;
    res_out.pnum       = cmd_r.pnum;
    res_out.skip       = cmd_r.skip;
    res_out.err        = err_r;
  end

  assign init_busy = init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_CLEAR;
      init_r    <= 1'b1;
      clr_r     <= '0;
      rem_cnt_r <= '0;
      max_col_r <= '0;
      max_row_r <= '0;
      pass2_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      init_r    <= init_nxt;
      clr_r     <= clr_nxt;
      rem_cnt_r <= rem_cnt_nxt;
      max_col_r <= max_col_nxt;
      max_row_r <= max_row_nxt;
      pass2_r   <= pass2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    r_r     <= r_nxt;
    c_r     <= c_nxt;
    sum_r   <= sum_nxt;
    num_r   <= num_nxt;
    old_r   <= old_nxt;
    share_r <= share_nxt;
    err_r   <= err_nxt;
    omap_r  <= omap_nxt;
    octb_r  <= octb_nxt;
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[addr] <= map_wd;
    if (ctb_we) ctb_mem[addr] <= ctb_wd;
    if (rd_en) begin
      rd_map_r <= map_mem[addr];
      rd_ctb_r <= ctb_mem[addr];
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into a full queue");

  a_extra_spent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DONE) |-> (rem_cnt_r == '0))
    else $error("remainder bits not fully distributed");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == BK_DIV)) else $error("divider finished while not awaited");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == BK_IDLE && !init_r))
    else $error("command taken while busy or clearing");

endmodule

`default_nettype wire

### hw/rtl/block_bit_map_accumulator.sv
`default_nettype none

// Block bit map accumulator: keeps, per 16x16 block of one picture, the coded
// bits, the quantizer (unsigned 6.8), and the bits and index of the covering
// coding unit and coding tree block. Both sides behave as queues: push an item
// while in_full is low, take one result per item while out_empty is low. Every
// item, including start-picture and add items, yields exactly one result.
// A front end checks geometry and tracks picture order, size and skipping;
// a command queue decouples it from the back end, which does all map accesses
// through single-port memories, one block access at a time, and shares one
// bit-serial divider for averaging and spreading. A start picture with a new
// picture order clears the whole map; the same clearing pass runs after
// reset, during which in_full stays high.
module block_bit_map_accumulator #(
  parameter int GRID_COLS       = 128,
  parameter int GRID_ROWS       = 128,
  parameter int MAX_UNIT_BLOCKS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [10:0]        in_x_pixel,
  input  wire logic [10:0]        in_y_pixel,
  input  wire logic [6:0]         in_unit_size,
  input  wire logic [23:0]        in_unit_bits,
  input  wire logic [5:0]         in_unit_qp,
  input  wire logic [15:0]        in_tree_block_index,
  input  wire logic signed [31:0] in_picture_order,
  input  wire logic [10:0]        in_picture_width,
  input  wire logic [10:0]        in_picture_height,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [23:0]             out_block_bits,
  output logic [5:0]              out_block_qp,
  output logic [23:0]             out_coding_unit_bits,
  output logic [23:0]             out_tree_block_bits,
  output logic [15:0]             out_tree_block_id,
  output logic [6:0]              out_last_col,
  output logic [6:0]              out_last_row,
  output logic [15:0]             out_picture_number,
  output logic                    out_skipping,
  output logic [1:0]              out_error_code
);

  import bbm_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t             front_cmd, back_cmd;
  res_t             back_res, out_res;
  logic [CMD_W-1:0] cmd_q_data;
  logic [RES_W-1:0] res_q_data;
  logic             accept, cmd_full, cmd_empty, cmd_pop;
  logic             res_full, res_push, init_busy;

  // The queue stays closed while the map is swept after reset.
  assign in_full = cmd_full || init_busy;
  assign accept  = in_push && !in_full;

  bbm_front #(
    .GRID_COLS       (GRID_COLS),
    .GRID_ROWS       (GRID_ROWS),
    .MAX_UNIT_BLOCKS (MAX_UNIT_BLOCKS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .opcode           (in_opcode),
    .x_pixel          (in_x_pixel),
    .y_pixel          (in_y_pixel),
    .unit_size        (in_unit_size),
    .unit_bits        (in_unit_bits),
    .unit_qp          (in_unit_qp),
    .tree_block_index (in_tree_block_index),
    .picture_order    (in_picture_order),
    .picture_width    (in_picture_width),
    .picture_height   (in_picture_height),
    .cmd              (front_cmd)
  );

  bbm_fifo #(.WIDTH(CMD_W), .DEPTH(4)) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (front_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_q_data),
    .empty     (cmd_empty)
  );

  assign back_cmd = cmd_t'(cmd_q_data);

  bbm_back #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_in    (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_out   (back_res),
    .res_full  (res_full),
    .res_push  (res_push),
    .init_busy (init_busy)
  );

  // Result queue: the back end starts the next command while a result waits.
  bbm_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (back_res),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_q_data),
    .empty     (out_empty)
  );

  assign out_res              = res_t'(res_q_data);
  assign out_block_bits       = out_res.block_bits;
  assign out_block_qp         = out_res.block_qp;
  assign out_coding_unit_bits = out_res.cu_bits;
  assign out_tree_block_bits  = out_res.ctb_bits;
  assign out_tree_block_id    = out_res.ctb_id;
  assign out_last_col         = out_res.last_col;
  assign out_last_row         = out_res.last_row;
  assign out_picture_number   = out_res.pnum;
  assign out_skipping         = out_res.skip;
  assign out_error_code       = out_res.err;

endmodule

`default_nettype wire

### tb/tb_block_bit_map_accumulator.sv
`default_nettype none

// Self-checking bench for the block bit map accumulator.
// Every accepted item is fed to an in-bench model of the block map that
// predicts the single result the item produces. Results are compared in order
// against the queue of predictions. The run steps through directed corner
// cases, a quantizer averaging and count saturation walk, and then random
// traffic under four idling profiles.
module tb_block_bit_map_accumulator;
  import bbm_pkg::*;

  localparam int GCOLS = 128;
  localparam int GROWS = 128;
  localparam int CELLS = GCOLS * GROWS;
  localparam int MAXB  = 4;
  localparam int unsigned MASK24 = 24'hFFFFFF;

  typedef struct packed {
    opcode_t     op;
    logic [10:0] x;
    logic [10:0] y;
    logic [6:0]  size;
    logic [23:0] bits;
    logic [5:0]  qp;
    logic [15:0] idx;
    logic [31:0] poc;
    logic [10:0] w;
    logic [10:0] h;
  } item_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_opcode;
  logic [10:0] in_x_pixel, in_y_pixel;
  logic [6:0]  in_unit_size;
  logic [23:0] in_unit_bits;
  logic [5:0]  in_unit_qp;
  logic [15:0] in_tree_block_index;
  logic signed [31:0] in_picture_order;
  logic [10:0] in_picture_width, in_picture_height;
  logic        out_empty;
  logic        out_pop;
  logic [23:0] out_block_bits;
  logic [5:0]  out_block_qp;
  logic [23:0] out_coding_unit_bits;
  logic [23:0] out_tree_block_bits;
  logic [15:0] out_tree_block_id;
  logic [6:0]  out_last_col, out_last_row;
  logic [15:0] out_picture_number;
  logic        out_skipping;
  logic [1:0]  out_error_code;

  block_bit_map_accumulator #(
    .GRID_COLS(GCOLS),
    .GRID_ROWS(GROWS),
    .MAX_UNIT_BLOCKS(MAXB)
  ) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_opcode(in_opcode), .in_x_pixel(in_x_pixel), .in_y_pixel(in_y_pixel),
    .in_unit_size(in_unit_size), .in_unit_bits(in_unit_bits),
    .in_unit_qp(in_unit_qp), .in_tree_block_index(in_tree_block_index),
    .in_picture_order(in_picture_order), .in_picture_width(in_picture_width),
    .in_picture_height(in_picture_height),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_block_bits(out_block_bits), .out_block_qp(out_block_qp),
    .out_coding_unit_bits(out_coding_unit_bits),
    .out_tree_block_bits(out_tree_block_bits),
    .out_tree_block_id(out_tree_block_id),
    .out_last_col(out_last_col), .out_last_row(out_last_row),
    .out_picture_number(out_picture_number), .out_skipping(out_skipping),
    .out_error_code(out_error_code)
  );

  // Model of the block map. Quantizers are kept in unsigned 6.8 form.
  int unsigned map_bits[CELLS];
  int unsigned map_qp[CELLS];
  int unsigned map_cu_bits[CELLS];
  int unsigned map_cnt[CELLS];
  int unsigned map_ctb_bits[CELLS];
  int unsigned map_ctb_idx[CELLS];
  logic [31:0] cur_poc;
  logic [15:0] pic_count;
  int unsigned pic_w, pic_h, hi_col, hi_row;
  bit          skip_pic;

  res_t result_q[$];
  int   mismatches;
  int   idle_pct;
  int   stall_pct;

  function automatic void clear_map();
    for (int i = 0; i < CELLS; i++) begin
      map_bits[i] = 0; map_qp[i] = 0; map_cu_bits[i] = 0;
      map_cnt[i] = 0; map_ctb_bits[i] = 0; map_ctb_idx[i] = 0;
    end
    hi_col = 0;
    hi_row = 0;
  endfunction

  function automatic void note_high(int unsigned c, int unsigned r);
    if (c > hi_col) hi_col = c;
    if (r > hi_row) hi_row = r;
  endfunction

  // Number of blocks, from the first one and at most n, inside the extent.
  function automatic int unsigned blocks_inside(int unsigned first, int unsigned n,
                                                int unsigned extent);
    int unsigned total;
    total = (extent + 15) / 16;
    if (first >= total) return 0;
    total -= first;
    return (total < n) ? total : n;
  endfunction

  // Geometry check shared by large units and tree blocks.
  function automatic logic [1:0] unit_region(input int unsigned x, y, size,
      output int unsigned xb, yb, nc, nr);
    int unsigned n;
    xb = 0; yb = 0; nc = 0; nr = 0;
    if (size % 16 != 0 || size <= 16) return ERR_GEOM;
    if (x % 16 != 0 || y % 16 != 0) return ERR_GEOM;
    n = size / 16;
    if (n > MAXB) return ERR_GEOM;
    xb = x / 16;
    yb = y / 16;
    nc = blocks_inside(xb, n, pic_w);
    nr = blocks_inside(yb, n, pic_h);
    if (nc == 0 || nr == 0) return ERR_OUTSIDE;
    if (xb + nc > GCOLS || yb + nr > GROWS) return ERR_GEOM;
    return ERR_OK;
  endfunction

  function automatic logic [1:0] apply_unit(item_t it);
    int unsigned xb, yb, nc, nr, i, share, extra, s, c;
    logic [1:0] e;
    if (it.size < 16) begin
      xb = it.x / 16;
      yb = it.y / 16;
      if (xb >= GCOLS || yb >= GROWS) return ERR_GEOM;
      note_high(xb, yb);
      i = yb * GCOLS + xb;
      s = map_bits[i] + it.bits;
      map_bits[i] = (s > MASK24) ? MASK24 : s;
      s = map_cu_bits[i] + it.bits;
      map_cu_bits[i] = (s > MASK24) ? MASK24 : s;
      c = map_cnt[i];
      map_qp[i] = ((map_qp[i] * c + (int'(it.qp) << 8)) / (c + 1)) & 16'hFFFF;
      map_cnt[i] = (c < 15) ? c + 1 : 15;
      return ERR_OK;
    end
    if (it.size == 16) begin
      if (it.x % 16 != 0 || it.y % 16 != 0) return ERR_GEOM;
      xb = it.x / 16;
      yb = it.y / 16;
      if (xb >= GCOLS || yb >= GROWS) return ERR_GEOM;
      note_high(xb, yb);
      i = yb * GCOLS + xb;
      map_bits[i] = it.bits;
      map_qp[i] = int'(it.qp) << 8;
      map_cu_bits[i] = it.bits;
      map_cnt[i] = 1;
      return ERR_OK;
    end
    e = unit_region(it.x, it.y, it.size, xb, yb, nc, nr);
    if (e != ERR_OK) return ERR_GEOM;
    share = it.bits / (nc * nr);
    extra = it.bits % (nc * nr);
    for (int r = 0; r < nr; r++) begin
      for (int k = 0; k < nc; k++) begin
        i = (yb + r) * GCOLS + xb + k;
        map_bits[i] = share;
        if (extra > 0) begin
          map_bits[i] += 1;
          extra--;
        end
        map_qp[i] = int'(it.qp) << 8;
        map_cu_bits[i] = it.bits;
        map_cnt[i] = 0;
      end
    end
    note_high(xb + nc - 1, yb + nr - 1);
    return ERR_OK;
  endfunction

  function automatic logic [1:0] apply_tree(item_t it);
    int unsigned xb, yb, nc, nr, i, sum, rest, share;
    logic [1:0] e;
    if (skip_pic) return ERR_OK;
    e = unit_region(it.x, it.y, it.size, xb, yb, nc, nr);
    if (e != ERR_OK) return e;
    sum = 0;
    for (int r = 0; r < nr; r++)
      for (int k = 0; k < nc; k++)
        sum += map_bits[(yb + r) * GCOLS + xb + k];
    if (sum > it.bits) return ERR_SHORT;
    rest = it.bits - sum;
    share = rest / (nc * nr);
    rest -= share * nc * nr;
    for (int r = 0; r < nr; r++) begin
      for (int k = 0; k < nc; k++) begin
        i = (yb + r) * GCOLS + xb + k;
        map_ctb_bits[i] = it.bits;
        map_ctb_idx[i] = it.idx;
        map_bits[i] += share;
        if (rest > 0) begin
          map_bits[i] += 1;
          rest--;
        end
      end
    end
    return ERR_OK;
  endfunction

  // Updates the map for one item and returns the result it must produce.
  function automatic res_t predict_result(item_t it);
    res_t r;
    int unsigned i;
    r = '0;
    r.err = ERR_OK;
    case (it.op)
      OP_START: begin
        if (it.poc != cur_poc) begin
          clear_map();
          cur_poc = it.poc;
          pic_count++;
          pic_w = it.w;
          pic_h = it.h;
          skip_pic = 0;
        end else begin
          skip_pic = 1;
        end
      end
      OP_CU:  r.err = apply_unit(it);
      OP_CTB: r.err = apply_tree(it);
      default: begin
        if (it.x / 16 >= GCOLS || it.y / 16 >= GROWS) begin
          r.err = ERR_GEOM;
        end else begin
          i = (it.y / 16) * GCOLS + it.x / 16;
          r.block_bits = 24'(map_bits[i]);
          r.block_qp   = 6'(map_qp[i] >> 8);
          r.cu_bits    = 24'(map_cu_bits[i]);
          r.ctb_bits   = 24'(map_ctb_bits[i]);
          r.ctb_id     = 16'(map_ctb_idx[i]);
        end
      end
    endcase
    r.last_col = 7'(hi_col);
    r.last_row = 7'(hi_row);
    r.pnum     = pic_count - 16'd1;
    r.skip     = skip_pic;
    return r;
  endfunction

  // Presents one item, holds it until accepted, and records its prediction.
  // The push line stays high when the next item follows without a gap.
  task automatic send_item(item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push             <= 1'b1;
    in_opcode           <= it.op;
    in_x_pixel          <= it.x;
    in_y_pixel          <= it.y;
    in_unit_size        <= it.size;
    in_unit_bits        <= it.bits;
    in_unit_qp          <= it.qp;
    in_tree_block_index <= it.idx;
    in_picture_order    <= it.poc;
    in_picture_width    <= it.w;
    in_picture_height   <= it.h;
    do @(posedge clk); while (in_full);
    result_q.push_back(predict_result(it));
  endtask

  function automatic item_t make_item(opcode_t op, int unsigned x, int unsigned y,
      int unsigned size, int unsigned bits, int unsigned qp = 0,
      int unsigned idx = 0);
    item_t it;
    it.op = op; it.x = 11'(x); it.y = 11'(y); it.size = 7'(size);
    it.bits = 24'(bits); it.qp = 6'(qp); it.idx = 16'(idx);
    // Picture fields carry noise on non-start items; the block ignores them.
    it.poc = $urandom;
    it.w = 11'($urandom);
    it.h = 11'($urandom);
    return it;
  endfunction

  function automatic item_t start_item(logic [31:0] poc, int unsigned w, int unsigned h);
    item_t it;
    it = make_item(OP_START, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    it.poc = poc;
    it.w = 11'(w);
    it.h = 11'(h);
    return it;
  endfunction

  task automatic wait_drained();
    in_push <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // Corner cases: saturating 8x8 sums, misaligned and oversized units,
  // remainder spreading, partly covered units, tree block errors and skipping.
  task automatic test_directed();
    send_item(make_item(OP_READ, 2047, 2047, 0, 0));
    send_item(start_item(32'h8000_0000, 40, 40));
    send_item(make_item(OP_CU, 9, 15, 8, MASK24, 63));
    send_item(make_item(OP_CU, 8, 8, 0, MASK24, 0));
    send_item(make_item(OP_READ, 15, 15, 0, 0));
    send_item(make_item(OP_CU, 16, 0, 16, 12345, 17));
    send_item(make_item(OP_CU, 8, 0, 16, 5, 5));
    send_item(make_item(OP_CU, 0, 16, 32, 7, 40));
    send_item(make_item(OP_CU, 16, 16, 20, 7, 40));
    send_item(make_item(OP_CU, 16, 16, 80, 7, 40));
    send_item(make_item(OP_CU, 32, 32, 64, 1001, 33));
    send_item(make_item(OP_CU, 1024, 1024, 48, 99, 1));
    send_item(make_item(OP_CU, 32, 32, 8, 3, 9));
    send_item(make_item(OP_READ, 47, 47, 0, 0));
    send_item(make_item(OP_CTB, 0, 0, 64, 16, 0, 16'hFFFF));
    send_item(make_item(OP_CTB, 0, 0, 64, MASK24, 0, 16'hA5A5));
    send_item(make_item(OP_CTB, 1024, 0, 64, MASK24, 0, 3));
    send_item(make_item(OP_READ, 16, 16, 0, 0));
    send_item(start_item(32'h8000_0000, 7, 9));
    send_item(make_item(OP_CTB, 0, 0, 32, MASK24, 0, 1));
    send_item(make_item(OP_CU, 0, 0, 16, 77, 2));
    send_item(make_item(OP_READ, 0, 0, 0, 0));
    send_item(start_item(32'h7FFF_FFFF, 2047, 2047));
    send_item(make_item(OP_CU, 2032, 2032, 64, MASK24, 63));
    send_item(make_item(OP_READ, 2047, 2047, 0, 0));
    wait_drained();
  endtask

  // A large unit leaves a zero count, so the next 8x8 unit takes its own
  // quantizer; then the count runs up to its limit of fifteen.
  task automatic test_qp_average();
    send_item(make_item(OP_CU, 64, 64, 32, 400, 50));
    send_item(make_item(OP_CU, 64, 64, 8, 10, 10));
    for (int k = 0; k < 18; k++) begin
      send_item(make_item(OP_CU, 64 + (k % 2) * 8, 64, 4, 1 << 20, $urandom_range(63)));
      if (k % 6 == 5) send_item(make_item(OP_READ, 64, 64, 0, 0));
    end
    wait_drained();
  endtask

  function automatic int unsigned place(int unsigned extent);
    int unsigned n;
    n = (extent + 15) / 16;
    if (n == 0 || $urandom_range(9) == 0) return $urandom_range(127) * 16;
    return $urandom_range(n - 1) * 16;
  endfunction

  // Random traffic: mostly tree blocks with coding units inside them and
  // reads of the same area, with picture starts and raw noise mixed in.
  task automatic test_random(int n_items, int idle, int stall);
    int sent;
    int unsigned bx, by, sz, pick;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        if ($urandom_range(1) == 0)
          send_item(start_item($urandom, $urandom_range(1, 2047), $urandom_range(1, 2047)));
        else
          send_item(start_item(cur_poc, $urandom, $urandom));
        sent++;
      end else if (pick < 60) begin
        bx = place(pic_w);
        by = place(pic_h);
        sz = $urandom_range(2, MAXB) * 16;
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(2))
            0: send_item(make_item(OP_CU, bx + $urandom_range(sz - 1),
                                   by + $urandom_range(sz - 1), $urandom_range(8, 15),
                                   $urandom_range(4000), $urandom));
            1: send_item(make_item(OP_CU, bx + $urandom_range(sz / 16 - 1) * 16,
                                   by + $urandom_range(sz / 16 - 1) * 16, 16,
                                   $urandom_range(4000), $urandom));
            default: send_item(make_item(OP_CU, bx, by, sz, $urandom_range(8000), $urandom));
          endcase
          sent++;
        end
        send_item(make_item(OP_CTB, bx, by, sz,
                            ($urandom_range(7) == 0) ? $urandom_range(3000)
                                                     : $urandom_range(70000, MASK24),
                            $urandom, $urandom));
        sent++;
        repeat ($urandom_range(1, 3)) begin
          send_item(make_item(OP_READ, bx + $urandom_range(sz - 1),
                              by + $urandom_range(sz - 1), $urandom, $urandom));
          sent++;
        end
      end else if (pick < 80) begin
        send_item(make_item(OP_READ, $urandom, $urandom, $urandom, $urandom));
        sent++;
      end else begin
        send_item(make_item(opcode_t'($urandom_range(1, 3)), $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom));
        sent++;
      end
    end
    wait_drained();
  endtask

  // Result side: check each accepted result, then choose the next pop.
  always @(posedge clk) begin
    res_t got, want;
    if (out_pop && !out_empty) begin
      got = '{out_block_bits, out_block_qp, out_coding_unit_bits, out_tree_block_bits,
              out_tree_block_id, out_last_col, out_last_row, out_picture_number,
              out_skipping, out_error_code};
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing pending: %p", got);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch bits %h/%h qp %0d/%0d cu %h/%h ctb %h/%h id %h/%h",
                     want.block_bits, got.block_bits, want.block_qp, got.block_qp,
                     want.cu_bits, got.cu_bits, want.ctb_bits, got.ctb_bits,
                     want.ctb_id, got.ctb_id);
            $display("  col %0d/%0d row %0d/%0d pic %0d/%0d skip %0d/%0d err %0d/%0d",
                     want.last_col, got.last_col, want.last_row, got.last_row,
                     want.pnum, got.pnum, want.skip, got.skip, want.err, got.err);
          end
        end
      end
    end
    out_pop <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("block_bit_map_accumulator regression: fail");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    out_pop = 1'b0;
    in_opcode = '0; in_x_pixel = '0; in_y_pixel = '0; in_unit_size = '0;
    in_unit_bits = '0; in_unit_qp = '0; in_tree_block_index = '0;
    in_picture_order = '0; in_picture_width = '0; in_picture_height = '0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    clear_map();
    cur_poc = 32'hFFFF_FFFF;
    pic_count = '0;
    pic_w = 0;
    pic_h = 0;
    skip_pic = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_qp_average();
    test_random(240, 0, 0);
    test_random(240, 79, 0);
    test_random(240, 0, 79);
    test_random(230, 16, 16);

    // The last result can pop before the block has settled.
    repeat (100) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0)
      $display("block_bit_map_accumulator regression: pass");
    else
      $display("block_bit_map_accumulator regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
